// ===== design/json_string_field_extractor_core_assert.svh =====
// ---------------------------------------------------------------------------
// JSON string field extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define JSON_STRING_FIELD_EXTRACTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JSFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JSFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jsfe_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON string field extractor package
// Transaction types, character codes, register indexes and queue sizing.
// ---------------------------------------------------------------------------
package jsfe_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_LEN_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH     = 2'd2;

    // Character codes
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Outcome codes
    localparam logic [1:0] OUTCOME_NONE         = 2'd0;
    localparam logic [1:0] OUTCOME_COMPLETE     = 2'd1;
    localparam logic [1:0] OUTCOME_UNTERMINATED = 2'd2;

    // Result queue between the scanner and the output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_byte_valid;
        logic       done_res;
        logic [1:0] outcome;
    } out_item_t;

endpackage

// ===== design/json_string_field_extractor_core.sv =====
// A result passes through a result queue entry and the output register before it appears on out_valid.
// One byte per cycle while the result queue is not full; the window compare and phase decision are combinational.
// The four-entry result queue and the output register hold five results while out_ready is low.
// Reset (rst_n low, asynchronous) clears the key registers, scan phase, fill count and queue.
// No clearing pass is needed after reset; bytes are accepted as soon as reset is released.
// ---------------------------------------------------------------------------
// JSON string field extractor core
// Finds a quoted key in a byte stream and extracts its string value.
// ---------------------------------------------------------------------------
module json_string_field_extractor_core #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [jsfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [jsfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  jsfe_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output jsfe_pkg::out_item_t               out_data
);

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;
    jsfe_pkg::out_item_t  q_item;
    jsfe_pkg::out_item_t  q_head;

    // Scanner
    jsfe_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // Result queue
    jsfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    // Output stage
    jsfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ===== design/jsfe_front.sv =====
// ---------------------------------------------------------------------------
// JSON string field extractor scanner
// Holds the key registers and the byte window, matches the quoted key and
// runs the scan phase machine, producing at most one result per byte.
// ---------------------------------------------------------------------------
`include "json_string_field_extractor_core_assert.svh"

module jsfe_front #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration writes
    input  logic                                cfg_write,
    input  logic [jsfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jsfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input byte transactions
    input  logic                                in_valid,
    output logic                                in_ready,
    input  jsfe_pkg::in_item_t                  in_data,
    // Result queue write side
    input  logic                                q_full,
    output logic                                q_push,
    output jsfe_pkg::out_item_t                 q_item
);

    localparam int WIN_DEPTH = MAX_KEY_BYTES + 2;
    localparam int HIST_D    = MAX_KEY_BYTES + 1;
    localparam int LEN_W     = $clog2(MAX_KEY_BYTES + 1);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int KIDX_W    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_SLOTS = 1 << KIDX_W;

    typedef enum logic [2:0] {
        PH_SEEK_KEY,
        PH_SEEK_COLON,
        PH_SKIP_SPACE,
        PH_IN_VALUE,
        PH_IN_ESCAPE,
        PH_DONE
    } phase_t;

    logic [jsfe_pkg::CFG_DATA_W-1:0]  key_low_reg;
    logic [jsfe_pkg::CFG_DATA_W-1:0]  key_high_reg;
    logic [jsfe_pkg::KEY_LEN_W-1:0]   key_len_reg;

    logic [7:0]        hist_reg [0:HIST_D-1];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    phase_t            phase_reg;
    phase_t            phase_next;

    logic [2*jsfe_pkg::CFG_DATA_W-1:0] key_all;
    logic [7:0]        key_ch [0:KEY_SLOTS-1];
    logic [LEN_W-1:0]  eff_len;
    logic [FILL_W-1:0] span;
    logic              marker_hit;
    logic              accept;
    logic [7:0]        b;
    logic              eom;
    logic              is_space;
    logic              res_valid;
    logic              res_done;
    logic [1:0]        res_outcome;
    logic [LEN_W-1:0]  kdiff;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                jsfe_pkg::REG_KEY_BYTES_LOW:  key_low_reg  <= cfg_data;
                jsfe_pkg::REG_KEY_BYTES_HIGH: key_high_reg <= cfg_data;
                jsfe_pkg::REG_KEY_LENGTH:
                    key_len_reg <= cfg_data[jsfe_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;
    assign b        = in_data.data_byte;
    assign eom      = in_data.end_of_message;

    // Key characters, first character at slot 0
    assign key_all = {key_high_reg, key_low_reg};
    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            key_ch[i] = key_all[8*i +: 8];
        end
    end

    // Key length clamped to MAX_KEY_BYTES, so the quoted key fits the window
    always_comb
    begin
        if (key_len_reg > jsfe_pkg::KEY_LEN_W'(MAX_KEY_BYTES))
        begin
            eff_len = LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = key_len_reg[LEN_W-1:0];
        end
    end

    // Window fill count including the byte now arriving
    always_comb
    begin
        if (fill_reg < FILL_W'(WIN_DEPTH))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    assign span = FILL_W'(eff_len) + FILL_W'(2);

    // Marker match: new byte is the closing quote, the oldest byte of the
    // span is the opening quote, and the bytes in between spell the key.
    always_comb
    begin
        kdiff      = '0;
        marker_hit = (fill_next >= span) && (b == jsfe_pkg::CH_QUOTE)
                     && (hist_reg[eff_len] == jsfe_pkg::CH_QUOTE);
        for (int j = 1; j <= MAX_KEY_BYTES; j++)
        begin
            kdiff = eff_len - LEN_W'(j);
            if (LEN_W'(j) <= eff_len)
            begin
                if (hist_reg[j-1] != key_ch[kdiff[KIDX_W-1:0]])
                begin
                    marker_hit = 1'b0;
                end
            end
        end
    end

    // Whitespace classification
    always_comb
    begin
        case (b) inside
            jsfe_pkg::CH_SPACE, jsfe_pkg::CH_TAB, jsfe_pkg::CH_CR, jsfe_pkg::CH_LF:
                is_space = 1'b1;
            default:
                is_space = 1'b0;
        endcase
    end

    // Phase transition and result classification
    always_comb
    begin
        phase_next  = phase_reg;
        res_valid   = 1'b0;
        res_done    = 1'b0;
        res_outcome = jsfe_pkg::OUTCOME_NONE;
        unique case (phase_reg)
            PH_SEEK_KEY:
            begin
                if (marker_hit)
                begin
                    phase_next = PH_SEEK_COLON;
                end
            end
            PH_SEEK_COLON:
            begin
                if (b == jsfe_pkg::CH_COLON)
                begin
                    phase_next = PH_SKIP_SPACE;
                end
            end
            PH_SKIP_SPACE:
            begin
                if (b == jsfe_pkg::CH_QUOTE)
                begin
                    phase_next = PH_IN_VALUE;
                end
                else if (!is_space)
                begin
                    res_done   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_IN_VALUE:
            begin
                if (b == jsfe_pkg::CH_BACKSLASH)
                begin
                    phase_next = PH_IN_ESCAPE;
                end
                else if (b == jsfe_pkg::CH_QUOTE)
                begin
                    res_done    = 1'b1;
                    res_outcome = jsfe_pkg::OUTCOME_COMPLETE;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    res_valid = 1'b1;
                end
            end
            PH_IN_ESCAPE:
            begin
                res_valid  = 1'b1;
                phase_next = PH_IN_VALUE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // End of message without an earlier decision closes the message.
        if (eom && !res_done && (phase_reg != PH_DONE))
        begin
            res_done = 1'b1;
            if ((phase_next == PH_IN_VALUE) || (phase_next == PH_IN_ESCAPE))
            begin
                res_outcome = jsfe_pkg::OUTCOME_UNTERMINATED;
            end
            else
            begin
                res_outcome = jsfe_pkg::OUTCOME_NONE;
            end
        end
    end

    // Result transaction toward the queue
    assign q_push                = accept && (res_valid || res_done);
    assign q_item.value_byte     = res_valid ? b : 8'h00;
    assign q_item.value_byte_valid = res_valid;
    assign q_item.done_res       = res_done;
    assign q_item.outcome        = res_done ? res_outcome : jsfe_pkg::OUTCOME_NONE;

    // Byte history, newest previous byte at index 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg[0] <= b;
            for (int k = 1; k < HIST_D; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // Scan phase and window fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK_KEY;
            fill_reg  <= '0;
        end
        else if (accept)
        begin
            if (eom)
            begin
                phase_reg <= PH_SEEK_KEY;
                fill_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                fill_reg  <= fill_next;
            end
        end
    end

    // Assertions
    `JSFE_ASSERT_NEXT(a_eom_restarts, accept && eom,
        (phase_reg == PH_SEEK_KEY) && (fill_reg == '0), "end of message did not restart scan")
    `JSFE_ASSERT_SAME(a_done_silent, accept && (phase_reg == PH_DONE) && !eom,
        !q_push, "result produced after the decision")
    `JSFE_ASSERT_SAME(a_push_meaningful, q_push,
        q_item.value_byte_valid || q_item.done_res, "empty result pushed")

endmodule

// ===== design/jsfe_queue.sv =====
// ---------------------------------------------------------------------------
// JSON string field extractor result queue
// Small FIFO that decouples the scanner from the output stage.
// ---------------------------------------------------------------------------
`include "json_string_field_extractor_core_assert.svh"

module jsfe_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jsfe_pkg::out_item_t  push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output jsfe_pkg::out_item_t  head_item
);

    jsfe_pkg::out_item_t                entries_reg [0:jsfe_pkg::QUEUE_DEPTH-1];
    logic [jsfe_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [jsfe_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [jsfe_pkg::QUEUE_CNT_W-1:0]   count_reg;

    assign full      = (count_reg == jsfe_pkg::QUEUE_CNT_W'(jsfe_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entries_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Assertions
    `JSFE_ASSERT_SAME(a_no_overflow, push && full, pop, "push into a full queue")
    `JSFE_ASSERT_SAME(a_no_underflow, pop, not_empty, "pop from an empty queue")
    `JSFE_ASSERT_NEXT(a_count_up, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "occupancy did not follow a push")

endmodule

// ===== design/jsfe_back.sv =====
// ---------------------------------------------------------------------------
// JSON string field extractor output stage
// Drains the result queue into a registered output transaction.
// ---------------------------------------------------------------------------
module jsfe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  jsfe_pkg::out_item_t  q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output jsfe_pkg::out_item_t  out_data
);

    logic                 out_valid_reg;
    jsfe_pkg::out_item_t  out_data_reg;

    // Load whenever the output register is empty or being taken.
    assign q_pop     = q_not_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= q_head;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// JSON string field extractor testbench
// Feeds quoted-key messages through bursty valid/ready traffic, predicts each
// value byte and final outcome with a behavioral scanner, and checks the
// output stream in order under several key settings.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int WINDOW_DEPTH  = 18;
    localparam int KEY_BYTES     = 16;
    localparam int LONG_HOLD     = 120;
    localparam int PHASE_ITEMS   = 210;
    localparam int SETTLE_CYCLES = 4;
    localparam int KEY_SETTINGS  = 8;
    localparam int PRESSURE_SET  = 4;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [jsfe_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        SEEK_KEY, SEEK_COLON, SKIP_SPACE, IN_VALUE, IN_ESCAPE, DECIDED
    } scan_state_t;

    typedef enum logic [2:0] {
        WELL_FORMED, CORRUPTED, NOISE, NOT_STRING, WRONG_KEY
    } msg_kind_t;

    typedef enum logic [1:0] {
        RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC
    } ready_mode_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [jsfe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [jsfe_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    jsfe_pkg::in_item_t               in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    jsfe_pkg::out_item_t              out_data;

    // Scanner model state and its copy of the key registers.
    logic [127:0]                     key_text  = '0;
    logic [jsfe_pkg::KEY_LEN_W-1:0]   key_count = '0;
    logic [7:0]                       window [WINDOW_DEPTH];
    int                               window_fill;
    scan_state_t                      scan_state;

    // Bytes waiting to be offered and results still owed by the block.
    jsfe_pkg::in_item_t               pending_bytes [$];
    jsfe_pkg::out_item_t              expected_values [$];
    int                               items_queued = 0;
    int                               items_taken  = 0;
    int                               error_count  = 0;
    logic                             in_taken     = 1'b0;

    // Sender burst state.
    int                     burst_left = 0;
    int                     gap_left   = 0;

    // Receiver stall state.
    int                     holds_asked  = 0;
    int                     holds_served = 0;
    int                     hold_left    = 0;
    int                     mode_left    = 0;
    int                     rx_tick      = 0;
    ready_mode_t            ready_mode   = RX_ALWAYS;

    json_string_field_extractor_core #(
        .MAX_KEY_BYTES(KEY_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // A message boundary drops the window and restarts the key search.
    function automatic void clear_message();
        int i;
        for (i = 0; i < WINDOW_DEPTH; i++)
            window[i] = 8'h00;
        window_fill = 0;
        scan_state = SEEK_KEY;
    endfunction

    // True when the newest bytes read as the quoted key, newest byte last.
    function automatic bit marker_seen();
        int len;
        int span;
        int i;
        len = (key_count > KEY_BYTES) ? KEY_BYTES : key_count;
        span = len + 2;
        if (window_fill < span)
            return 1'b0;
        if (window[0] != jsfe_pkg::CH_QUOTE || window[span-1] != jsfe_pkg::CH_QUOTE)
            return 1'b0;
        for (i = 0; i < len; i++)
            if (window[span-2-i] != key_text[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advances the scanner by one byte and reports the result it causes, if any.
    function automatic void scan_byte(input jsfe_pkg::in_item_t item, output bit emits,
                                      output jsfe_pkg::out_item_t res);
        scan_state_t nxt;
        logic [7:0]  b;
        logic [7:0]  vb;
        logic        valid;
        logic        done;
        logic [1:0]  oc;
        int          i;
        b = item.data_byte;
        nxt = scan_state;
        vb = 8'h00;
        valid = 1'b0;
        done = 1'b0;
        oc = jsfe_pkg::OUTCOME_NONE;

        for (i = WINDOW_DEPTH - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (window_fill < WINDOW_DEPTH)
            window_fill++;

        case (scan_state)
            SEEK_KEY:
                if (marker_seen())
                    nxt = SEEK_COLON;
            SEEK_COLON:
                if (b == jsfe_pkg::CH_COLON)
                    nxt = SKIP_SPACE;
            SKIP_SPACE:
                if (b == jsfe_pkg::CH_QUOTE)
                    nxt = IN_VALUE;
                else if (!(b inside {jsfe_pkg::CH_SPACE, jsfe_pkg::CH_TAB,
                                     jsfe_pkg::CH_CR, jsfe_pkg::CH_LF}))
                begin
                    done = 1'b1;
                    oc = jsfe_pkg::OUTCOME_NONE;
                    nxt = DECIDED;
                end
            IN_VALUE:
                if (b == jsfe_pkg::CH_BACKSLASH)
                    nxt = IN_ESCAPE;
                else if (b == jsfe_pkg::CH_QUOTE)
                begin
                    done = 1'b1;
                    oc = jsfe_pkg::OUTCOME_COMPLETE;
                    nxt = DECIDED;
                end
                else
                begin
                    vb = b;
                    valid = 1'b1;
                end
            IN_ESCAPE:
            begin
                vb = b;
                valid = 1'b1;
                nxt = IN_VALUE;
            end
            default:
                nxt = DECIDED;
        endcase

        // An undecided message is closed by its last byte.
        if (item.end_of_message && !done && scan_state != DECIDED)
        begin
            done = 1'b1;
            oc = (nxt == IN_VALUE || nxt == IN_ESCAPE) ? jsfe_pkg::OUTCOME_UNTERMINATED
                                                       : jsfe_pkg::OUTCOME_NONE;
        end

        if (item.end_of_message)
            clear_message();
        else
            scan_state = nxt;

        emits = valid || done;
        res.value_byte = valid ? vb : 8'h00;
        res.value_byte_valid = valid;
        res.done_res = done;
        res.outcome = done ? oc : jsfe_pkg::OUTCOME_NONE;
    endfunction

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    // Monitor: key register shadow, output check and prediction at the rising edge.
    always @(posedge clk)
    begin
        jsfe_pkg::out_item_t want;
        jsfe_pkg::out_item_t res;
        bit                  emits;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    jsfe_pkg::REG_KEY_BYTES_LOW:  key_text[63:0] = cfg_data;
                    jsfe_pkg::REG_KEY_BYTES_HIGH: key_text[127:64] = cfg_data;
                    jsfe_pkg::REG_KEY_LENGTH:
                        key_count = cfg_data[jsfe_pkg::KEY_LEN_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, out_data);
                end
                else
                begin
                    want = expected_values.pop_front();
                    compare_field("value_byte", want.value_byte, out_data.value_byte);
                    compare_field("value_byte_valid", 8'(want.value_byte_valid),
                                  8'(out_data.value_byte_valid));
                    compare_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
                    compare_field("outcome", 8'(want.outcome), 8'(out_data.outcome));
                end
            end

            if (in_valid && in_ready)
            begin
                scan_byte(in_data, emits, res);
                if (emits)
                    expected_values.push_back(res);
                items_taken++;
            end
        end
        in_taken <= in_valid && in_ready;
    end

    // Driver: offers queued bytes in bursts separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                in_data <= pending_bytes.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    gap_left = $urandom_range(1, 6);
                    if ($urandom_range(0, 5) == 0)
                        burst_left = $urandom_range(100, 300);
                    else
                        burst_left = $urandom_range(1, 20);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: switches between stall patterns, with an occasional long hold-off.
    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (ready_mode)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
                default:     out_ready <= (rx_tick % 3) != 0;
            endcase
        end
    end

    function automatic void push_byte(input logic [7:0] b, input logic last);
        jsfe_pkg::in_item_t item;
        item.data_byte = b;
        item.end_of_message = last;
        pending_bytes.push_back(item);
        items_queued++;
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
            c = 8'($urandom_range(0, 255));
        else
            c = 8'($urandom_range(8'h20, 8'h7E));
        return c;
    endfunction

    function automatic logic [7:0] space_byte();
        case ($urandom_range(0, 3))
            0:       return jsfe_pkg::CH_SPACE;
            1:       return jsfe_pkg::CH_TAB;
            2:       return jsfe_pkg::CH_CR;
            default: return jsfe_pkg::CH_LF;
        endcase
    endfunction

    // Any byte that does not end or escape the value.
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == jsfe_pkg::CH_QUOTE || c == jsfe_pkg::CH_BACKSLASH)
            c = 8'h76;
        return c;
    endfunction

    function automatic logic [63:0] letter_word();
        logic [63:0] w;
        int          i;
        for (i = 0; i < 8; i++)
            w[8*i +: 8] = 8'($urandom_range(8'h61, 8'h7A));
        return w;
    endfunction

    // Builds one message around the current key, mostly well formed.
    task automatic queue_message(input bit long_value);
        logic [7:0] msg [$];
        msg_kind_t  kind;
        int         klen;
        int         key_at;
        int         open_at;
        int         vlen;
        int         cut;
        int         j;
        int         i;
        klen = (key_count > KEY_BYTES) ? KEY_BYTES : key_count;
        j = $urandom_range(0, 9);
        kind = (long_value || j < 6) ? WELL_FORMED : msg_kind_t'(j - 5);

        repeat ($urandom_range(0, 6))
            msg.push_back(filler_byte());
        msg.push_back(jsfe_pkg::CH_QUOTE);
        key_at = msg.size();
        for (i = 0; i < klen; i++)
            msg.push_back(key_text[8*i +: 8]);
        msg.push_back(jsfe_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 2))
            msg.push_back(space_byte());
        msg.push_back(jsfe_pkg::CH_COLON);
        repeat ($urandom_range(0, 3))
            msg.push_back(space_byte());
        open_at = msg.size();
        msg.push_back(jsfe_pkg::CH_QUOTE);
        vlen = long_value ? $urandom_range(20, 40) : $urandom_range(0, 8);
        for (i = 0; i < vlen; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                msg.push_back(jsfe_pkg::CH_BACKSLASH);
                msg.push_back(8'($urandom_range(0, 255)));
            end
            else
                msg.push_back(value_char());
        end
        msg.push_back(jsfe_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 4))
            msg.push_back(filler_byte());

        case (kind)
            CORRUPTED:
            begin
                j = $urandom_range(0, msg.size() - 1);
                msg[j] = 8'($urandom_range(0, 255));
            end
            NOISE:
            begin
                msg.delete();
                repeat ($urandom_range(1, 12))
                    msg.push_back(8'($urandom_range(0, 255)));
            end
            NOT_STRING:
                msg[open_at] = 8'($urandom_range(8'h30, 8'h39));
            WRONG_KEY:
            begin
                j = key_at + $urandom_range(0, (klen > 0) ? klen - 1 : 0);
                msg[j] = msg[j] ^ 8'h20;
            end
            default:
            begin
                // Some messages stop short, at any point in the message.
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(1, msg.size());
                    while (msg.size() > cut)
                        void'(msg.pop_back());
                end
            end
        endcase

        for (i = 0; i < msg.size(); i++)
            push_byte(msg[i], i == msg.size() - 1);
    endtask

    // Returns once every byte is taken and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_taken != items_queued || expected_values.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jsfe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [jsfe_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        int          setting;
        int          start_count;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        clear_message();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_UNUSED, {$urandom(), $urandom()});

        // With the reset key length of zero, two adjacent quotes form the marker.
        // Marker completed on the last byte.
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b1);
        // Empty value.
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_COLON, 1'b0);
        push_byte(jsfe_pkg::CH_SPACE, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b1);
        // Escaped byte on the last byte of the message.
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_COLON, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(jsfe_pkg::CH_BACKSLASH, 1'b0);
        push_byte(8'h00, 1'b1);
        // A single byte message with no decision.
        push_byte(jsfe_pkg::CH_TAB, 1'b1);
        // Non-string value decides early; the rest of the message is ignored.
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_COLON, 1'b0);
        push_byte(8'h35, 1'b0);
        push_byte(8'h80, 1'b1);
        // Key changed in the middle of a message.
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        wait_idle();
        write_reg(jsfe_pkg::REG_KEY_BYTES_LOW, 64'h61);
        write_reg(jsfe_pkg::REG_KEY_LENGTH, 64'd1);
        push_byte(8'h61, 1'b0);
        push_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        push_byte(jsfe_pkg::CH_COLON, 1'b1);
        wait_idle();

        // Random messages under several key settings.
        for (setting = 0; setting < KEY_SETTINGS; setting++)
        begin
            lo = letter_word();
            hi = letter_word();
            len_word = 64'd0;
            case (setting)
                0: len_word = 64'd16;
                1:
                begin
                    lo = '1;
                    hi = '1;
                    len_word = {$urandom(), $urandom()};
                    len_word[jsfe_pkg::KEY_LEN_W-1:0] = 5'd31;
                end
                2: len_word = 64'd0;
                3:
                begin
                    lo = '0;
                    hi = '0;
                    len_word = 64'd1;
                end
                default:
                begin
                    len_word = {$urandom(), $urandom()};
                    len_word[jsfe_pkg::KEY_LEN_W-1:0] =
                        jsfe_pkg::KEY_LEN_W'($urandom_range(2, 15));
                end
            endcase
            write_reg(jsfe_pkg::REG_KEY_BYTES_LOW, lo);
            write_reg(jsfe_pkg::REG_KEY_BYTES_HIGH, hi);
            write_reg(jsfe_pkg::REG_KEY_LENGTH, len_word);

            // Long values behind a long receiver hold-off back the block up.
            if (setting == PRESSURE_SET)
                holds_asked++;
            start_count = items_queued;
            while (items_queued - start_count < PHASE_ITEMS)
                queue_message(setting == PRESSURE_SET);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_values.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/jsfe_pkg.sv
design/jsfe_front.sv
design/jsfe_queue.sv
design/jsfe_back.sv
design/json_string_field_extractor_core.sv
bench/tb_top.sv
